@@ rtl/core/ksp_pkg.sv @@
// shared types, codes and defaults for the k-stacks shared pool
package ksp_pkg;

  localparam int CELLS_DEF  = 1024;
  localparam int STACKS_DEF = 8;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] STAT_DONE       = 2'd0;
  localparam logic [1:0] STAT_POOL_FULL  = 2'd1;
  localparam logic [1:0] STAT_STACK_EMPTY = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [2:0]         stack_select;
    logic signed [31:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
    logic               stack_now_empty;
    logic               pool_now_full;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic exec_go;
  } ctrl_t;

endpackage

@@ rtl/core/k_stacks_shared_pool.sv @@
// top level: several lifo stacks sharing one linked cell pool with a free list
// the input word and its cell read are registered on accept; the result is registered
// in the execute state; a new word is taken only after the link memory write-back
// a full output register stalls the write-back until the result is taken
// reset: synchronous, all stacks empty, free list chained through every cell
// the link memory is not swept; a fill count stands in for the untouched chain
module k_stacks_shared_pool #(
  parameter int CELLS  = ksp_pkg::CELLS_DEF,
  parameter int STACKS = ksp_pkg::STACKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ksp_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ksp_pkg::out_word_t out_data
);
  import ksp_pkg::*;

  localparam int AW = $clog2(CELLS);
  localparam int LW = $clog2(CELLS + 1);
  localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(CELLS);

  function automatic logic [SW-1:0] stack_index(input logic [2:0] s);
    logic [8:0] v;
    v = 9'(s);
    for (int i = 0; i < 8; i++) begin
      if (v >= 9'(STACKS)) v = v - 9'(STACKS);
    end
    return SW'(v);
  endfunction

  logic [LW-1:0] link_mem [CELLS];
  logic [31:0]   val_mem  [CELLS];
  logic [LW-1:0] link_q;
  logic [31:0]   val_q;

  logic [LW-1:0] heads_r [STACKS];
  logic [LW-1:0] free_head_r;
  logic [LW-1:0] free_head_nxt;
  logic [LW-1:0] fill_r;
  logic [LW-1:0] fill_nxt;

  logic               op_cmd_r;
  logic [SW-1:0]      op_sel_r;
  logic signed [31:0] op_val_r;
  logic [LW-1:0]      op_cell_r;

  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t res;

  ctrl_t ctrl;
  logic  acc;
  logic  go;

  logic [SW-1:0] sel_in;
  logic [LW-1:0] cell_sel;
  logic          rd_en;
  logic [LW-1:0] link_eff;
  logic [LW-1:0] head_cur;
  logic          head_we;
  logic [LW-1:0] head_wdata;
  logic          mem_we;
  logic [LW-1:0] link_wdata;

  ksp_fsm u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_valid_r && !out_ready),
    .ctrl     (ctrl)
  );

  assign in_ready = ctrl.in_ready;
  assign acc      = in_valid && ctrl.in_ready;
  assign go       = ctrl.exec_go;

  // address of the cell this word works on
  assign sel_in   = stack_index(in_data.stack_select);
  assign cell_sel = (in_data.cmd == CMD_PUSH) ? free_head_r : heads_r[sel_in];
  assign rd_en    = acc && (cell_sel != NULL_LINK);

  always_ff @(posedge clk) begin
    if (rd_en) link_q <= link_mem[cell_sel[AW-1:0]];
    if (go && mem_we) link_mem[op_cell_r[AW-1:0]] <= link_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) val_q <= val_mem[cell_sel[AW-1:0]];
    if (go && mem_we && (op_cmd_r == CMD_PUSH)) val_mem[op_cell_r[AW-1:0]] <= op_val_r;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_cmd_r  <= in_data.cmd;
      op_sel_r  <= sel_in;
      op_val_r  <= in_data.push_value;
      op_cell_r <= cell_sel;
    end
  end

  // cells at or above the fill count still hold the reset chain
  assign link_eff = (op_cell_r < fill_r) ? link_q : (op_cell_r + LW'(1));
  assign head_cur = heads_r[op_sel_r];

  always_comb begin
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    head_we       = 1'b0;
    head_wdata    = head_cur;
    mem_we        = 1'b0;
    link_wdata    = head_cur;
    res           = '0;
    if (op_cmd_r == CMD_PUSH) begin
      if (op_cell_r == NULL_LINK) begin
        res.status          = STAT_POOL_FULL;
        res.stack_now_empty = (head_cur == NULL_LINK);
        res.pool_now_full   = 1'b1;
      end else begin
        mem_we        = 1'b1;
        link_wdata    = head_cur;
        head_we       = 1'b1;
        head_wdata    = op_cell_r;
        free_head_nxt = link_eff;
        if (op_cell_r == fill_r) fill_nxt = fill_r + LW'(1);
        res.status          = STAT_DONE;
        res.stack_now_empty = 1'b0;
        res.pool_now_full   = (link_eff == NULL_LINK);
      end
    end else begin
      if (op_cell_r == NULL_LINK) begin
        res.status          = STAT_STACK_EMPTY;
        res.stack_now_empty = 1'b1;
        res.pool_now_full   = (free_head_r == NULL_LINK);
      end else begin
        mem_we        = 1'b1;
        link_wdata    = free_head_r;
        head_we       = 1'b1;
        head_wdata    = link_eff;
        free_head_nxt = op_cell_r;
        res.status          = STAT_DONE;
        res.pop_value       = val_q;
        res.stack_now_empty = (link_eff == NULL_LINK);
        res.pool_now_full   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STACKS; i++) heads_r[i] <= NULL_LINK;
      free_head_r <= '0;
      fill_r      <= '0;
    end else if (go) begin
      if (head_we) heads_r[op_sel_r] <= head_wdata;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/ksp_fsm.sv @@
// sequencer: accept a word, then read-modify-write once the output slot is free
module ksp_fsm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_busy,
  output ksp_pkg::ctrl_t ctrl
);
  import ksp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
      end
      ST_EXEC: begin
        ctrl.exec_go = !out_busy;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/ksp_checker.sv @@
// port-level checks for the k-stacks shared pool, bound to the top level
module ksp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input ksp_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input ksp_pkg::out_word_t out_data
);
  import ksp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_pop_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_STACK_EMPTY)
      |-> out_data.stack_now_empty && (out_data.pop_value == 0))
    else $error("refused pop with stack not empty or nonzero value");

  a_push_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_POOL_FULL)
      |-> out_data.pool_now_full && (out_data.pop_value == 0))
    else $error("refused push with pool not full or nonzero value");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind k_stacks_shared_pool ksp_checker u_ksp_checker (.*);
